[hdl/fta_pkg.sv]
// ----------------------------------------------------------------------------
// fta_pkg
// Types and codes shared by the fixed-timestep accumulator core and its
// iterative divider.
// ----------------------------------------------------------------------------
package fta_pkg;

    // Item kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_TIME_SCALE = 2'd0;
    localparam logic [1:0] REG_FIXED_STEP = 2'd1;
    localparam logic [1:0] REG_MAX_TICKS  = 2'd2;

    localparam logic [15:0] TIME_SCALE_RESET = 16'd256;
    localparam logic [31:0] FIXED_STEP_RESET = 32'd16666667;
    localparam logic [7:0]  MAX_TICKS_RESET  = 8'd5;

    localparam int ALPHA_BITS   = 16;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] elapsed_ns;
    } req_word_t;

    typedef struct packed {
        logic        tick_granted;
        logic [7:0]  ticks_this_frame;
        logic        catch_up_clamped;
        logic [63:0] dropped_total;
        logic [47:0] accumulated_ns;
        logic [16:0] interp_alpha;
    } rsp_word_t;

    // Divider operation: fraction of the step for alpha, or whole steps in
    // the accumulator for the backlog drop.
    typedef enum logic {
        DIV_ALPHA,
        DIV_WHOLE
    } div_mode_t;

    typedef struct packed {
        logic      start;
        div_mode_t mode;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hdl/fixed_timestep_accumulator_core.sv]
// Sequence: a frame update multiplies and adds, a tick request decides on a
// grant; alpha is then one if the accumulator ends at or above the step, else
// a division; a tick request that drops backlog runs a whole-step division first.
// Throughput: one word at a time, set by the shared one-bit-per-cycle divider;
// the next word is taken the cycle after the result leaves.
// Reset: state clears; registers return to scale 1.0, step 16666667 ns, limit 5.
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator_core
// Fixed-timestep credit accumulator: frame updates add scaled time, tick
// requests consume whole steps under a per-frame limit, and every item
// reports the state and the interpolation alpha.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator_core
    import fta_pkg::*;
#(
    parameter int ACC_BITS        = 48,
    parameter int TICK_COUNT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_word_t   req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_word_t   rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SUM_W = ACC_BITS + 1;
    localparam int CMP_W = (TICK_COUNT_BITS > 8) ? TICK_COUNT_BITS : 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_TICK,
        S_DROP_WAIT,
        S_ALPHA,
        S_ALPHA_WAIT,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [31:0]                elapsed_reg, elapsed_next;
    logic [39:0]                add_reg, add_next;
    logic [ACC_BITS-1:0]        acc_reg, acc_next;
    logic [TICK_COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                       flag_reg, flag_next;
    logic [63:0]                dropped_reg, dropped_next;
    logic                       granted_reg, granted_next;
    logic [16:0]                alpha_reg, alpha_next;

    logic [15:0]                scale_reg;
    logic [31:0]                step_reg;
    logic [7:0]                 max_reg;

    logic [47:0]                prod;
    logic [SUM_W-1:0]           sum;
    logic                       acc_ge;
    logic                       acc_due;
    logic                       at_limit;
    logic [CMP_W-1:0]           cnt_ext;

    div_cmd_t                   div_cmd;
    div_stat_t                  div_stat;
    logic [ACC_BITS-1:0]        div_quo;
    logic [31:0]                div_rem;

    fta_divider #(
        .W (ACC_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (div_cmd),
        .acc     (acc_reg),
        .divisor (step_reg),
        .stat    (div_stat),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Configuration: a zero step is ignored, a zero limit stores as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= TIME_SCALE_RESET;
            step_reg  <= FIXED_STEP_RESET;
            max_reg   <= MAX_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_SCALE: scale_reg <= cfg_data[15:0];
                REG_FIXED_STEP:
                begin
                    if (cfg_data != 32'd0)
                        step_reg <= cfg_data;
                end
                REG_MAX_TICKS:  max_reg <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    assign prod     = 48'(elapsed_reg) * 48'(scale_reg);
    assign sum      = {1'b0, acc_reg} + SUM_W'(add_reg);
    assign acc_ge   = acc_reg >= ACC_BITS'(step_reg);
    assign acc_due  = acc_reg >= ACC_BITS'(step_reg - 32'd1);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign at_limit = (cnt_ext >= CMP_W'(max_reg)) || (&cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        elapsed_next = elapsed_reg;
        add_next     = add_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        flag_next    = flag_reg;
        dropped_next = dropped_reg;
        granted_next = granted_reg;
        alpha_next   = alpha_reg;
        div_cmd      = '{start: 1'b0, mode: DIV_ALPHA};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next    = req.kind;
                    elapsed_next = req.elapsed_ns;
                    granted_next = 1'b0;
                    case (req.kind)
                        KIND_FRAME: state_next = S_MUL;
                        KIND_TICK:  state_next = S_TICK;
                        KIND_CLEAR:
                        begin
                            acc_next   = '0;
                            state_next = S_ALPHA;
                        end
                        default:    state_next = S_ALPHA;
                    endcase
                end
            end
            S_MUL:
            begin
                add_next   = prod[47:8];
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // Saturate on carry out of the accumulator
                acc_next   = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
                cnt_next   = '0;
                flag_next  = 1'b0;
                state_next = S_ALPHA;
            end
            S_TICK:
            begin
                state_next = S_ALPHA;
                if (at_limit)
                begin
                    if (acc_ge)
                    begin
                        div_cmd    = '{start: 1'b1, mode: DIV_WHOLE};
                        state_next = S_DROP_WAIT;
                    end
                end
                else if (acc_due)
                begin
                    acc_next     = acc_ge ? acc_reg - ACC_BITS'(step_reg) : '0;
                    cnt_next     = cnt_reg + 1'b1;
                    granted_next = 1'b1;
                end
            end
            S_DROP_WAIT:
            begin
                if (div_stat.done)
                begin
                    acc_next     = ACC_BITS'(div_rem);
                    dropped_next = dropped_reg + 64'(div_quo);
                    flag_next    = 1'b1;
                    state_next   = S_ALPHA;
                end
            end
            S_ALPHA:
            begin
                if (acc_ge)
                begin
                    alpha_next = ALPHA_ONE;
                    state_next = S_OUT;
                end
                else
                begin
                    div_cmd    = '{start: 1'b1, mode: DIV_ALPHA};
                    state_next = S_ALPHA_WAIT;
                end
            end
            S_ALPHA_WAIT:
            begin
                if (div_stat.done)
                begin
                    alpha_next = {1'b0, div_quo[ALPHA_BITS-1:0]};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kind_reg    <= KIND_FRAME;
            elapsed_reg <= '0;
            add_reg     <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            flag_reg    <= 1'b0;
            dropped_reg <= '0;
            granted_reg <= 1'b0;
            alpha_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            elapsed_reg <= elapsed_next;
            add_reg     <= add_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            flag_reg    <= flag_next;
            dropped_reg <= dropped_next;
            granted_reg <= granted_next;
            alpha_reg   <= alpha_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    assign rsp.tick_granted     = granted_reg;
    assign rsp.ticks_this_frame = cnt_ext[7:0];
    assign rsp.catch_up_clamped = flag_reg;
    assign rsp.dropped_total    = dropped_reg;
    assign rsp.accumulated_ns   = 48'(acc_reg);
    assign rsp.interp_alpha     = alpha_reg;

    // A granted tick always leaves a nonzero frame count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.tick_granted |-> cnt_reg != '0)
        else $error("tick granted with zero frame count");

    // A frame update result shows a fresh frame
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && kind_reg == KIND_FRAME |-> cnt_reg == '0 && !flag_reg)
        else $error("frame update did not clear frame state");

    // Alpha never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> alpha_reg <= ALPHA_ONE)
        else $error("alpha above one");

    // The divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DROP_WAIT || state_reg == S_ALPHA_WAIT)
        else $error("divider result with no one waiting");

    // After a backlog drop the accumulator holds less than one step
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DROP_WAIT && div_stat.done |=> !acc_ge && flag_reg)
        else $error("backlog drop left a whole step");

endmodule

[hdl/fta_divider.sv]
// ----------------------------------------------------------------------------
// fta_divider
// Restoring divider, one quotient bit per cycle, shared by the backlog drop
// (accumulator / step) and the interpolation alpha (accumulator * 2^16 / step).
// ----------------------------------------------------------------------------
module fta_divider
    import fta_pkg::*;
#(
    parameter int W = 48
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  div_cmd_t     cmd,
    input  logic [W-1:0] acc,
    input  logic [31:0]  divisor,
    output div_stat_t    stat,
    output logic [W-1:0] quo,
    output logic [31:0]  rem
);

    localparam int CW = $clog2(W + 1);

    logic [31:0]   rem_reg;
    logic [W-1:0]  quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (cmd.mode == DIV_ALPHA) ? CW'(ALPHA_BITS) : CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Alpha starts with the accumulator as remainder (it is below the step)
    // and shifts in zeros; the whole-step case shifts the accumulator in.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            if (cmd.mode == DIV_ALPHA)
            begin
                rem_reg <= acc[31:0];
                quo_reg <= '0;
            end
            else
            begin
                rem_reg <= '0;
                quo_reg <= acc;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-timestep accumulator core. A short table
// of directed words runs first, then bursts of frame updates and tick
// requests under nine register settings and three idling patterns. Every
// report word is checked field by field against a predictor kept in the
// bench, or against the typed report of its table row where it has one.
// ----------------------------------------------------------------------------
module tb_top;
    import fta_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W = 48;
    localparam int TICK_W = 8;
    localparam logic [63:0] ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;
    localparam logic [7:0] TICK_MAX = 8'hFF;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DIR_ROWS = 21;
    localparam int SETTINGS = 9;
    localparam int SEG_WORDS = 180;
    localparam int HOLD_CYCLES = 400;

    localparam rsp_word_t NO_CREDIT = '0;
    localparam rsp_word_t ONE_STEP_TAKEN = {1'b1, 8'd1, 1'b0, 64'd0, 48'd0, 17'd0};
    localparam rsp_word_t FULL_STEP_HELD =
        {1'b0, 8'd0, 1'b0, 64'd0, 48'd16666667, ALPHA_ONE};

    typedef struct packed {
        req_word_t word;
        logic      typed;
        rsp_word_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_word_t   req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_word_t   rsp;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_TIME_SCALE;
    logic [31:0] cfg_data = '0;

    // Predictor state and register copies
    logic [15:0] scale_q8 = TIME_SCALE_RESET;
    logic [31:0] step_ns = FIXED_STEP_RESET;
    logic [7:0]  tick_limit = MAX_TICKS_RESET;
    logic [63:0] acc_ns = '0;
    logic [7:0]  frame_ticks = '0;
    logic        clamp_flag = 1'b0;
    logic [63:0] drop_total = '0;

    rsp_word_t   timestep_reports_q [$];
    dir_row_t    dir_tab [DIR_ROWS];

    int unsigned snd_idle_pct = 29;
    int unsigned rcv_idle_pct = 87;
    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    int unsigned error_count = 0;
    int unsigned words_sent = 0;
    int unsigned grants_seen = 0;
    int unsigned clamps_seen = 0;
    int unsigned saturated_seen = 0;

    fixed_timestep_accumulator_core #(
        .ACC_BITS        (ACC_W),
        .TICK_COUNT_BITS (TICK_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Advance the accumulator by one word and return the report it produces.
    function automatic rsp_word_t advance_timestep(req_word_t w);
        rsp_word_t   r;
        logic [63:0] stepw;
        logic [63:0] addend;
        logic [63:0] sum;
        logic [63:0] whole;
        logic        granted;
        granted = 1'b0;
        stepw = {32'd0, step_ns};
        case (w.kind)
            KIND_FRAME:
            begin
                addend = ({32'd0, w.elapsed_ns} * {48'd0, scale_q8}) >> 8;
                sum = acc_ns + addend;
                if (sum > ACC_LIMIT)
                    sum = ACC_LIMIT;
                acc_ns = sum;
                frame_ticks = '0;
                clamp_flag = 1'b0;
            end
            KIND_TICK:
            begin
                if (frame_ticks >= tick_limit || frame_ticks == TICK_MAX)
                begin
                    // at the limit: drop the whole-step backlog
                    if (acc_ns >= stepw - 64'd1)
                    begin
                        whole = acc_ns / stepw;
                        if (whole != 0)
                        begin
                            drop_total = drop_total + whole;
                            acc_ns = acc_ns % stepw;
                            clamp_flag = 1'b1;
                        end
                    end
                end
                else if (acc_ns >= stepw - 64'd1)
                begin
                    acc_ns = (acc_ns >= stepw) ? acc_ns - stepw : 64'd0;
                    frame_ticks = frame_ticks + 8'd1;
                    granted = 1'b1;
                end
            end
            KIND_CLEAR:
                acc_ns = '0;
            default:
                ;
        endcase
        r.tick_granted = granted;
        r.ticks_this_frame = frame_ticks;
        r.catch_up_clamped = clamp_flag;
        r.dropped_total = drop_total;
        r.accumulated_ns = acc_ns[47:0];
        r.interp_alpha = (acc_ns >= stepw) ? ALPHA_ONE : 17'((acc_ns << 16) / stepw);
        return r;
    endfunction

    function automatic void apply_cfg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_TIME_SCALE:
                scale_q8 = data[15:0];
            REG_FIXED_STEP:
            begin
                if (data != 0)
                    step_ns = data;
            end
            REG_MAX_TICKS:
                tick_limit = (data[7:0] == 8'd0) ? 8'd1 : data[7:0];
            default:
                ;
        endcase
    endfunction

    function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic void setting_for(input int seg, output logic [31:0] sc,
                                        output logic [31:0] st, output logic [31:0] li);
        case (seg)
            0: begin sc = 32'd256;   st = 32'd1000;        li = 32'd5;   end
            1: begin sc = 32'd0;     st = 32'd1;           li = 32'd1;   end
            2: begin sc = 32'd65535; st = 32'hFFFF_FFFF;   li = 32'd255; end
            3: begin sc = 32'd384;   st = 32'd0;           li = 32'd0;   end
            4: begin sc = 32'd200;   st = 32'd7;           li = 32'd3;   end
            5: begin sc = 32'd256;   st = 32'd16666667;    li = 32'd5;   end
            6: begin sc = 32'd1000;  st = 32'd33333;       li = 32'd8;   end
            7: begin sc = 32'd1;     st = 32'd123456;      li = 32'd2;   end
            default: begin sc = 32'd65535; st = 32'd1;     li = 32'd255; end
        endcase
    endfunction

    task automatic send_word(req_word_t w, logic typed, rsp_word_t typed_rsp);
        rsp_word_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (req_stall);
        predicted = advance_timestep(w);
        timestep_reports_q.push_back(typed ? typed_rsp : predicted);
        words_sent++;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        apply_cfg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid and let every outstanding report come back.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (timestep_reports_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // One frame update sized to a few steps and a run of tick requests, or a
    // single noise word.
    task automatic run_burst();
        req_word_t   w;
        int unsigned pick;
        int unsigned n;
        int unsigned ticks;
        int unsigned lim_small;
        logic        catch_up_run;
        logic [63:0] stepw;
        logic [63:0] target;
        logic [63:0] e;
        pick = $urandom_range(0, 99);
        stepw = {32'd0, step_ns};
        lim_small = (tick_limit > 8'd6) ? 6 : int'(tick_limit);
        if (pick < 10)
        begin
            w.kind = 2'($urandom_range(0, 3));
            w.elapsed_ns = $urandom;
            send_word(w, 1'b0, NO_CREDIT);
        end
        else if (pick < 15)
        begin
            w.kind = KIND_CLEAR;
            w.elapsed_ns = $urandom;
            send_word(w, 1'b0, NO_CREDIT);
        end
        else
        begin
            catch_up_run = ($urandom_range(0, 15) == 0);
            n = catch_up_run ? int'(tick_limit) + 2 : $urandom_range(0, lim_small + 2);
            target = stepw * 64'(n) + ({32'd0, $urandom} % stepw);
            if (scale_q8 == 16'd0)
                e = {32'd0, $urandom};
            else
                e = (target * 64'd256 + {48'd0, scale_q8} - 64'd1) / {48'd0, scale_q8};
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            w.kind = KIND_FRAME;
            w.elapsed_ns = e[31:0];
            send_word(w, 1'b0, NO_CREDIT);
            ticks = catch_up_run ? int'(tick_limit) + 2 : $urandom_range(0, lim_small + 3);
            repeat (ticks)
            begin
                w.kind = KIND_TICK;
                w.elapsed_ns = $urandom;
                send_word(w, 1'b0, NO_CREDIT);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_served)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin : check_reports
        rsp_word_t want;
        int        bad;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (timestep_reports_q.size() == 0)
            begin
                $error("report word arrived with none outstanding");
                error_count++;
            end
            else
            begin
                want = timestep_reports_q.pop_front();
                bad = field_bad("tick_granted", 64'(want.tick_granted), 64'(rsp.tick_granted))
                    + field_bad("ticks_this_frame", 64'(want.ticks_this_frame),
                                64'(rsp.ticks_this_frame))
                    + field_bad("catch_up_clamped", 64'(want.catch_up_clamped),
                                64'(rsp.catch_up_clamped))
                    + field_bad("dropped_total", want.dropped_total, rsp.dropped_total)
                    + field_bad("accumulated_ns", 64'(want.accumulated_ns),
                                64'(rsp.accumulated_ns))
                    + field_bad("interp_alpha", 64'(want.interp_alpha), 64'(rsp.interp_alpha));
                error_count += bad;
                if (rsp.tick_granted)
                    grants_seen++;
                if (rsp.catch_up_clamped)
                    clamps_seen++;
                if ({16'd0, rsp.accumulated_ns} == ACC_LIMIT)
                    saturated_seen++;
            end
        end
    end

    initial
    begin
        req_word_t   w;
        logic [31:0] sc;
        logic [31:0] st;
        logic [31:0] li;
        int unsigned seg_start;

        // Rows with a typed report start from the reset registers.
        dir_tab[0]  = {KIND_TICK,  32'd0,           1'b1, NO_CREDIT};
        dir_tab[1]  = {KIND_SPARE, 32'hFFFF_FFFF,   1'b1, NO_CREDIT};
        dir_tab[2]  = {KIND_FRAME, 32'd0,           1'b1, NO_CREDIT};
        dir_tab[3]  = {KIND_CLEAR, 32'hFFFF_FFFF,   1'b1, NO_CREDIT};
        dir_tab[4]  = {KIND_FRAME, 32'd16666667,    1'b1, FULL_STEP_HELD};
        dir_tab[5]  = {KIND_TICK,  32'd0,           1'b1, ONE_STEP_TAKEN};
        dir_tab[6]  = {KIND_FRAME, 32'd16666666,    1'b0, NO_CREDIT};
        // one ns short of a step still earns a tick
        dir_tab[7]  = {KIND_TICK,  32'd0,           1'b1, ONE_STEP_TAKEN};
        dir_tab[8]  = {KIND_FRAME, 32'hFFFF_FFFF,   1'b0, NO_CREDIT};
        dir_tab[9]  = {KIND_TICK,  32'hFFFF_FFFF,   1'b0, NO_CREDIT};
        dir_tab[10] = {KIND_TICK,  32'd0,           1'b0, NO_CREDIT};
        dir_tab[11] = {KIND_TICK,  32'hAAAA_5555,   1'b0, NO_CREDIT};
        dir_tab[12] = {KIND_TICK,  32'd0,           1'b0, NO_CREDIT};
        dir_tab[13] = {KIND_TICK,  32'd0,           1'b0, NO_CREDIT};
        dir_tab[14] = {KIND_TICK,  32'd0,           1'b0, NO_CREDIT};
        dir_tab[15] = {KIND_TICK,  32'd0,           1'b0, NO_CREDIT};
        dir_tab[16] = {KIND_SPARE, 32'h1234_5678,   1'b0, NO_CREDIT};
        dir_tab[17] = {KIND_FRAME, 32'd1,           1'b0, NO_CREDIT};
        dir_tab[18] = {KIND_CLEAR, 32'd0,           1'b0, NO_CREDIT};
        dir_tab[19] = {KIND_FRAME, 32'h8000_0000,   1'b0, NO_CREDIT};
        dir_tab[20] = {KIND_TICK,  32'h5555_AAAA,   1'b0, NO_CREDIT};

        wait (rst_n === 1'b1);
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);

        for (int seg = 0; seg < SETTINGS; seg++)
        begin
            settle();
            case (seg / 3)
                0: begin snd_idle_pct = 29; rcv_idle_pct = 87; end
                1: begin snd_idle_pct = 87; rcv_idle_pct = 29; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            setting_for(seg, sc, st, li);
            cfg_write(REG_TIME_SCALE, sc);
            cfg_write(REG_FIXED_STEP, st);
            cfg_write(REG_MAX_TICKS, li);
            if (seg == 3)
                cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
            seg_start = words_sent;
            if (seg == 6)
            begin
                // hold the report side off while words keep coming
                @(posedge clk);
                hold_reqs++;
            end
            if (seg == 2)
            begin
                // drive the accumulator into saturation, then tick past the limit
                repeat (260)
                begin
                    w.kind = KIND_FRAME;
                    w.elapsed_ns = 32'hFFFF_FFFF;
                    send_word(w, 1'b0, NO_CREDIT);
                end
                repeat (int'(tick_limit) + 3)
                begin
                    w.kind = KIND_TICK;
                    w.elapsed_ns = $urandom;
                    send_word(w, 1'b0, NO_CREDIT);
                end
            end
            while (words_sent - seg_start < SEG_WORDS)
                run_burst();
        end

        @(negedge clk);
        req_valid <= 1'b0;
        for (int i = 0; i < 5000 && timestep_reports_q.size() != 0; i++)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (timestep_reports_q.size() != 0)
            $error("%0d report words never arrived", timestep_reports_q.size());

        $display("Ran %0d words over %0d register settings and three idling patterns.",
                 words_sent, SETTINGS);
        $display("Saw %0d grants, %0d clamped reports, %0d saturated accumulator reports.",
                 grants_seen, clamps_seen, saturated_seen);
        if (error_count == 0 && timestep_reports_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
